FILE: rtl/core/tbgs_pkg.sv
// Package for the two-body gravity stepper: constants, register indexes,
// item opcodes, divide/root unit commands, item types and small helper functions. No dependencies.
package tbgs_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WORD_W = 32;
	localparam int DT_W = 16;
	localparam int DIR_W = 18;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHILD_MASS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PARENT_MASS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRAV_CONST = 2'd2;

	// item opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;
	localparam logic BODY_CHILD = 1'b0;
	localparam logic BODY_PARENT = 1'b1;

	// divider/root unit commands
	localparam logic [1:0] DU_DIV = 2'd0;
	localparam logic [1:0] DU_SQRT = 2'd1;

	// input item
	typedef struct packed {
		logic op;
		logic body;
		logic [WORD_W-1:0] load_x;
		logic [WORD_W-1:0] load_y;
		logic [WORD_W-1:0] load_vx;
		logic [WORD_W-1:0] load_vy;
		logic [DT_W-1:0] time_step;
	} body_item_t;

	// result item
	typedef struct packed {
		logic [WORD_W-1:0] child_x;
		logic [WORD_W-1:0] child_y;
		logic [WORD_W-1:0] child_vx;
		logic [WORD_W-1:0] child_vy;
		logic [WORD_W-1:0] parent_x;
		logic [WORD_W-1:0] parent_y;
		logic [WORD_W-1:0] parent_vx;
		logic [WORD_W-1:0] parent_vy;
		logic [DIR_W-1:0] dir_x;
		logic [DIR_W-1:0] dir_y;
		logic coincident;
	} body_state_t;

	typedef struct packed {
		logic [1:0] op;
		logic [65:0] num;
		logic [32:0] den;
	} du_req_t;

	// saturate a 34-bit signed sum to signed 32 bits
	function automatic logic [31:0] sat32(input logic signed [33:0] v);
		logic [31:0] r;
		if (v > 34'sd2147483647) r = 32'h7FFF_FFFF;
		else if (v < -34'sd2147483648) r = 32'h8000_0000;
		else r = v[31:0];
		return r;
	endfunction

	// saturate unsigned to 32 bits
	function automatic logic [31:0] usat32(input logic [65:0] v);
		return (|v[65:32]) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

endpackage

FILE: rtl/core/tbgs_if.sv
// Valid/ready channel interface for the gravity stepper.
// Payload type is a parameter; no package dependency.
interface tbgs_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/two_body_gravity_step_top.sv
// Two-body gravity stepper. A load item writes one body's state and goes through the S_OUT
// state before its result is valid. A step item runs on one bit-serial divide/root unit and
// one 33x33 multiplier under a sequencer: a square root, six divisions (two directions, two
// per acceleration) and the multiply, update and control steps; when the bodies coincide
// the divisions are skipped. The block takes no item while busy or while a result waits
// in the output register.
// Depends on tbgs_pkg, tbgs_if, tbgs_mul and tbgs_divsqrt.
module two_body_gravity_step_top
	import tbgs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [WORD_W-1:0] cfg_data,
	tbgs_if.sink in_ch,
	tbgs_if.source out_ch
);
	// sequencer steps
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_PMX = 5'd1;
	localparam logic [4:0] S_PMY = 5'd2;
	localparam logic [4:0] S_PMYW = 5'd3;
	localparam logic [4:0] S_SQX = 5'd4;
	localparam logic [4:0] S_SQY = 5'd5;
	localparam logic [4:0] S_SQW = 5'd6;
	localparam logic [4:0] S_ROOT = 5'd7;
	localparam logic [4:0] S_NX = 5'd8;
	localparam logic [4:0] S_NY = 5'd9;
	localparam logic [4:0] S_GM = 5'd10;
	localparam logic [4:0] S_GMW = 5'd11;
	localparam logic [4:0] S_T = 5'd12;
	localparam logic [4:0] S_A = 5'd13;
	localparam logic [4:0] S_DV = 5'd14;
	localparam logic [4:0] S_DVW = 5'd15;
	localparam logic [4:0] S_ALX = 5'd16;
	localparam logic [4:0] S_ALY = 5'd17;
	localparam logic [4:0] S_ALW = 5'd18;
	localparam logic [4:0] S_CMX = 5'd19;
	localparam logic [4:0] S_CMY = 5'd20;
	localparam logic [4:0] S_CMYW = 5'd21;
	localparam logic [4:0] S_OUT = 5'd22;
	localparam logic [4:0] S_SQS = 5'd23;

	logic [31:0] cmass_q, pmass_q, gconst_q;
	logic [31:0] cpx_q, cpy_q, cvx_q, cvy_q, ppx_q, ppy_q, pvx_q, pvy_q;
	logic [DT_W-1:0] dt_q;
	logic [4:0] st_q;
	logic body_q; // 0: parent accel pass, 1: child accel pass
	logic [32:0] ax_q, ay_q;
	logic sgx_q, sgy_q;
	logic [65:0] acc_q;
	logic [32:0] r_q;
	logic [DIR_W-2:0] nx_q, ny_q;
	logic [31:0] tmp_q;
	logic hit_q;
	logic out_v_q;
	logic [DIR_W-1:0] dirx_q, diry_q;

	logic [32:0] ma, mb;
	logic [65:0] mp;
	logic du_start;
	du_req_t du_req;
	logic du_done;
	logic [65:0] du_res;

	tbgs_mul u_mul (.clk(clk), .a(ma), .b(mb), .p_q(mp));
	tbgs_divsqrt u_du (.clk(clk), .arst_n(arst_n), .start(du_start), .req(du_req),
		.done(du_done), .result(du_res));

	// floor(v*dt/2^16) from a signed product held as 66 bits
	function automatic logic signed [33:0] dt_shift(input logic [65:0] p);
		logic signed [65:0] s;
		s = p;
		return 34'(s >>> DT_W);
	endfunction

	// multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (st_q)
			S_PMX: begin ma = {pvx_q[31], pvx_q}; mb = {17'd0, dt_q}; end
			S_PMY: begin ma = {pvy_q[31], pvy_q}; mb = {17'd0, dt_q}; end
			S_SQY: begin ma = ax_q; mb = ax_q; end
			S_SQW: begin ma = ay_q; mb = ay_q; end
			S_GM: begin ma = {1'b0, gconst_q}; mb = {1'b0, body_q ? pmass_q : cmass_q}; end
			S_DV: begin ma = {1'b0, tmp_q}; mb = {17'd0, dt_q}; end
			S_ALX: begin ma = {1'b0, tmp_q}; mb = {16'd0, nx_q}; end
			S_ALY: begin ma = {1'b0, tmp_q}; mb = {16'd0, ny_q}; end
			S_CMX: begin ma = {cvx_q[31], cvx_q}; mb = {17'd0, dt_q}; end
			S_CMY: begin ma = {cvy_q[31], cvy_q}; mb = {17'd0, dt_q}; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	// divide/root unit requests
	always_comb begin
		du_req = '0;
		case (st_q)
			S_ROOT: begin du_req.op = DU_SQRT; du_req.num = acc_q; end
			S_NX: begin du_req.num = 66'(ax_q) << FRAC_BITS; du_req.den = r_q; end
			S_NY: begin du_req.num = 66'(ay_q) << FRAC_BITS; du_req.den = r_q; end
			S_T, S_A: begin du_req.num = 66'(tmp_q) << FRAC_BITS; du_req.den = r_q; end
			default: du_req = '0;
		endcase
	end

	logic du_pend_q;
	logic signed [33:0] dx, dy;
	logic signed [33:0] alx, aly;
	assign dx = 34'(signed'(cpx_q)) - 34'(signed'(ppx_q));
	assign dy = 34'(signed'(cpy_q)) - 34'(signed'(ppy_q));
	assign alx = sgx_q ? -34'(mp[31+FRAC_BITS:FRAC_BITS]) : 34'(mp[31+FRAC_BITS:FRAC_BITS]);
	assign aly = sgy_q ? -34'(mp[31+FRAC_BITS:FRAC_BITS]) : 34'(mp[31+FRAC_BITS:FRAC_BITS]);

	assign in_ch.ready = (st_q == S_IDLE) && !out_v_q;
	assign out_ch.valid = out_v_q;
	assign out_ch.data.child_x = cpx_q;
	assign out_ch.data.child_y = cpy_q;
	assign out_ch.data.child_vx = cvx_q;
	assign out_ch.data.child_vy = cvy_q;
	assign out_ch.data.parent_x = ppx_q;
	assign out_ch.data.parent_y = ppy_q;
	assign out_ch.data.parent_vx = pvx_q;
	assign out_ch.data.parent_vy = pvy_q;
	assign out_ch.data.dir_x = dirx_q;
	assign out_ch.data.dir_y = diry_q;
	assign out_ch.data.coincident = hit_q;

	// sequencer; du_pend_q launches the unit once per divide or root state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			out_v_q <= 1'b0;
			du_pend_q <= 1'b0;
			cmass_q <= 32'(1) << FRAC_BITS;
			pmass_q <= 32'(1) << FRAC_BITS;
			gconst_q <= 32'(1) << FRAC_BITS;
			{cpx_q, cpy_q, cvx_q, cvy_q} <= '0;
			{ppx_q, ppy_q, pvx_q, pvy_q} <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CHILD_MASS: cmass_q <= cfg_data;
					REG_PARENT_MASS: pmass_q <= cfg_data;
					REG_GRAV_CONST: gconst_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) out_v_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						dt_q <= in_ch.data.time_step;
						hit_q <= 1'b0;
						dirx_q <= '0;
						diry_q <= '0;
						if (in_ch.data.op == OP_LOAD) begin
							if (in_ch.data.body == BODY_PARENT) begin
								ppx_q <= in_ch.data.load_x; ppy_q <= in_ch.data.load_y;
								pvx_q <= in_ch.data.load_vx; pvy_q <= in_ch.data.load_vy;
							end else begin
								cpx_q <= in_ch.data.load_x; cpy_q <= in_ch.data.load_y;
								cvx_q <= in_ch.data.load_vx; cvy_q <= in_ch.data.load_vy;
							end
							st_q <= S_OUT;
						end else begin
							st_q <= S_PMX;
						end
					end
				end
				S_PMX: st_q <= S_PMY;
				S_PMY: begin
					ppx_q <= sat32(34'(signed'(ppx_q)) + dt_shift(mp));
					st_q <= S_PMYW;
				end
				S_PMYW: begin
					ppy_q <= sat32(34'(signed'(ppy_q)) + dt_shift(mp));
					st_q <= S_SQX;
				end
				S_SQX: begin
					ax_q <= dx[33] ? 33'(-dx) : 33'(dx);
					ay_q <= dy[33] ? 33'(-dy) : 33'(dy);
					sgx_q <= dx[33];
					sgy_q <= dy[33];
					st_q <= S_SQY;
				end
				// ax^2 issued here, ay^2 next, then summed
				S_SQY: st_q <= S_SQW;
				S_SQW: begin
					acc_q <= mp;
					st_q <= S_SQS;
				end
				S_SQS: begin
					acc_q <= acc_q + mp;
					st_q <= S_ROOT;
				end
				S_ROOT, S_NX, S_NY, S_T, S_A: begin
					if (!du_pend_q) begin
						du_pend_q <= 1'b1;
					end else if (du_done) begin
						du_pend_q <= 1'b0;
						case (st_q)
							S_ROOT: begin
								r_q <= du_res[32:0];
								if (du_res[32:0] == '0) begin
									hit_q <= 1'b1;
									st_q <= S_CMX;
								end else begin
									st_q <= S_NX;
								end
							end
							S_NX: begin
								nx_q <= du_res[DIR_W-2:0];
								dirx_q <= sgx_q ? -DIR_W'(du_res[DIR_W-2:0])
									: DIR_W'(du_res[DIR_W-2:0]);
								st_q <= S_NY;
							end
							S_NY: begin
								ny_q <= du_res[DIR_W-2:0];
								diry_q <= sgy_q ? -DIR_W'(du_res[DIR_W-2:0])
									: DIR_W'(du_res[DIR_W-2:0]);
								body_q <= 1'b0;
								st_q <= S_GM;
							end
							S_T: begin tmp_q <= usat32(du_res); st_q <= S_A; end
							default: begin tmp_q <= usat32(du_res); st_q <= S_DV; end
						endcase
					end
				end
				S_GM: st_q <= S_GMW;
				S_GMW: begin
					tmp_q <= usat32(mp >> FRAC_BITS);
					st_q <= S_T;
				end
				S_DV: st_q <= S_DVW;
				S_DVW: begin
					tmp_q <= mp[47:16];
					st_q <= S_ALX;
				end
				S_ALX: st_q <= S_ALY;
				S_ALY: begin
					if (!body_q) pvx_q <= sat32(34'(signed'(pvx_q)) + alx);
					else cvx_q <= sat32(34'(signed'(cvx_q)) - alx);
					st_q <= S_ALW;
				end
				S_ALW: begin
					if (!body_q) begin
						pvy_q <= sat32(34'(signed'(pvy_q)) + aly);
						body_q <= 1'b1;
						st_q <= S_GM;
					end else begin
						cvy_q <= sat32(34'(signed'(cvy_q)) - aly);
						st_q <= S_CMX;
					end
				end
				S_CMX: st_q <= S_CMY;
				S_CMY: begin
					cpx_q <= sat32(34'(signed'(cpx_q)) + dt_shift(mp));
					st_q <= S_CMYW;
				end
				S_CMYW: begin
					cpy_q <= sat32(34'(signed'(cpy_q)) + dt_shift(mp));
					st_q <= S_OUT;
				end
				S_OUT: begin
					out_v_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign du_start = 1'b0 | ((st_q == S_ROOT || st_q == S_NX || st_q == S_NY
		|| st_q == S_T || st_q == S_A) && !du_pend_q);
endmodule

FILE: rtl/core/tbgs_divsqrt.sv
// Shared bit-serial unit: 66/33 restoring divide, or 66-bit integer root.
// One quotient or root bit per cycle. Depends on tbgs_pkg.
module tbgs_divsqrt
	import tbgs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input du_req_t req,
	output logic done,
	output logic [65:0] result
);
	localparam logic [6:0] DIV_STEPS = 7'd66;
	localparam logic [6:0] SQRT_STEPS = 7'd33;

	logic busy_q;
	logic is_sqrt_q;
	logic [6:0] cnt_q;
	logic [65:0] num_q;
	logic [32:0] den_q;
	logic [67:0] rem_q;
	logic [65:0] quo_q;

	logic [67:0] rem_sh;
	logic [67:0] trial;
	logic ge;

	// one step of divide or root
	always_comb begin
		if (is_sqrt_q) begin
			rem_sh = {rem_q[65:0], num_q[65:64]};
			trial = {quo_q[65:0], 2'b01};
		end else begin
			rem_sh = {rem_q[66:0], num_q[65]};
			trial = {35'd0, den_q};
		end
		ge = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				is_sqrt_q <= (req.op == DU_SQRT);
				cnt_q <= (req.op == DU_SQRT) ? SQRT_STEPS : DIV_STEPS;
				num_q <= req.num;
				den_q <= req.den;
				rem_q <= '0;
				quo_q <= '0;
			end else if (busy_q) begin
				rem_q <= ge ? rem_sh - trial : rem_sh;
				quo_q <= {quo_q[64:0], ge};
				num_q <= is_sqrt_q ? {num_q[63:0], 2'b00} : {num_q[64:0], 1'b0};
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	assign result = quo_q;
endmodule

FILE: rtl/core/tbgs_mul.sv
// Shared 33x33 signed multiplier with a registered product.
// Depends on tbgs_pkg.
module tbgs_mul
	import tbgs_pkg::*;
(
	input logic clk,
	input logic [32:0] a,
	input logic [32:0] b,
	output logic [65:0] p_q
);
	// unsigned operands arrive with a zero top bit
	always_ff @(posedge clk) begin
		p_q <= $signed({{33{a[32]}}, a}) * $signed({{33{b[32]}}, b});
	end
endmodule
